// ===== rtl/core/clsp_pkg.sv =====
// Shared types, codes and the pin-pair order for the charlieplex LED scanner.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package clsp_pkg;

  // Input item kinds carried on in_tuser.
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_OFF   = 2'd2
  } mode_t;

  localparam int unsigned IDX_W   = 7;   // led_index field width
  localparam int unsigned LEVEL_W = 8;   // level field width
  localparam int unsigned STORE_W = 3;   // stored brightness width
  localparam int unsigned PIN_W   = 11;  // pin vector width
  localparam int unsigned PNUM_W  = 4;   // pin number width
  localparam int unsigned TOTAL_W = 32;  // sweep counter width

  // One anode/cathode pair of the fixed charlieplex order.
  typedef struct packed {
    logic              valid;
    logic [PNUM_W-1:0] anode;
    logic [PNUM_W-1:0] cathode;
  } pair_t;

  // Command from the scanner to the level store for one processed item.
  typedef struct packed {
    logic               wr;
    logic               clr;
    logic [IDX_W-1:0]   wr_addr;
    logic [STORE_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
  } store_cmd_t;

  // Pair for LED n on a panel of pins pins. Pin h (from 1 up) owns the
  // 2*h entries starting at h*(h-1): (l high, h low) then (h high, l low)
  // for each l below h. Evaluated at elaboration only.
  function automatic pair_t pair_of(input int n, input int pins);
    pair_t p;
    int    base;
    int    k;
    p    = '0;
    base = 0;
    k    = 0;
    for (int h = 1; h < 16; h++) begin
      base = h * (h - 1);
      if (h < pins && n >= base && n < base + 2 * h) begin
        k       = n - base;
        p.valid = 1'b1;
        if (k[0] == 1'b0) begin
          p.anode   = PNUM_W'(k >> 1);
          p.cathode = PNUM_W'(h);
        end else begin
          p.anode   = PNUM_W'(h);
          p.cathode = PNUM_W'(k >> 1);
        end
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/clsp_level_store.sv =====
// Brightness store for the charlieplex scanner: one small memory with a valid bit per LED.
// Depends on clsp_pkg for the command struct and field widths.
`default_nettype none

module clsp_level_store #(
  parameter int unsigned LED_COUNT = 104
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire clsp_pkg::store_cmd_t            cmd,
  output logic [clsp_pkg::STORE_W-1:0]         rd_level
);

  localparam int unsigned AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic [clsp_pkg::STORE_W-1:0] mem [LED_COUNT];
  logic [LED_COUNT-1:0]         vld_r;
  logic [LED_COUNT-1:0]         vld_nxt;
  logic [clsp_pkg::STORE_W-1:0] mem_rd_r;
  logic [clsp_pkg::STORE_W-1:0] fwd_data_r;
  logic                         fwd_hit_r;
  logic                         rd_vld_r;
  logic [AW-1:0]                wa;
  logic [AW-1:0]                ra;
  logic                         hit;

  assign wa  = cmd.wr_addr[AW-1:0];
  assign ra  = cmd.rd_addr[AW-1:0];
  assign hit = cmd.wr && (wa == ra);

  // Memory write and registered read; the read sees the old word on a
  // same-address write, which the bypass below covers.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wa] <= cmd.wr_data;
    end
    mem_rd_r   <= mem[ra];
    fwd_data_r <= cmd.wr_data;
    fwd_hit_r  <= hit;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (cmd.clr) begin
      vld_nxt = '0;
    end else if (cmd.wr) begin
      vld_nxt[wa] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      rd_vld_r <= vld_nxt[ra];
    end
  end

  assign rd_level = !rd_vld_r ? '0 : (fwd_hit_r ? fwd_data_r : mem_rd_r);

endmodule

`default_nettype wire

// ===== rtl/core/charlieplex_led_scan_pwm_top.sv =====
// Top level of the charlieplex LED scanner with sweep-phase grayscale.
// Depends on clsp_pkg and instantiates clsp_level_store.
`default_nettype none

// The block takes one item per clock cycle while in_tready is high. An accepted
// item is held in an input register, where a constant pin-pair lookup,
// one small store read and a 3-bit compare decide its result, which lands in
// the output register as the item leaves the input register; out_tvalid is driven
// from that output register. The output register lets the
// next item be processed while a result still waits, so in_tready drops only
// when a result is pending and the item in the input register also makes one.
// A write item stores min(level, MAX_LEVEL) for one LED and starts scanning; a
// write to an LED beyond the panel stores nothing but still starts scanning.
// A tick while scanning gives the pins for the current slot (anode high,
// cathode low, all else floating, or all floating when the LED's level does
// not exceed the sweep phase) and advances the slot; at the end of a sweep the
// sweep counter increments and the phase advances modulo MAX_LEVEL. A tick
// while stopped gives nothing. An off item stops scanning, clears every level
// and gives an all-floating result with the current sweep total. The levels
// live in a small memory whose next slot is read ahead by a registered read; per-LED
// valid bits cleared at reset and by an off item make unwritten LEDs read as
// zero, so no clearing pass is needed.
module charlieplex_led_scan_pwm_top #(
  parameter int unsigned LED_COUNT = 104,
  parameter int unsigned MAX_LEVEL = 7,
  parameter int unsigned PIN_COUNT = 11
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [6:0] led_index, [14:7] level, [15] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // [10:0] pin_enable, [21:11] pin_high,
                                       // [53:22] sweep_total, [55:54] zero
);

  localparam int unsigned AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  // Input register.
  logic                          a_valid_r;
  clsp_pkg::mode_t               a_mode_r;
  logic [clsp_pkg::IDX_W-1:0]    a_idx_r;
  logic [clsp_pkg::LEVEL_W-1:0]  a_lvl_r;

  // Scan state.
  logic [AW-1:0]                 slot_r,  slot_nxt;
  logic [clsp_pkg::STORE_W-1:0]  phase_r, phase_nxt;
  logic [clsp_pkg::TOTAL_W-1:0]  count_r, count_nxt;
  logic                          scan_r,  scan_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic [clsp_pkg::PIN_W-1:0]    en_r, en_nxt;
  logic [clsp_pkg::PIN_W-1:0]    hi_r, hi_nxt;
  logic [clsp_pkg::TOTAL_W-1:0]  total_r, total_nxt;

  logic                          has_res;
  logic                          out_free;
  logic                          a_fire;
  logic [clsp_pkg::STORE_W-1:0]  cur_level;
  logic [clsp_pkg::STORE_W-1:0]  sat_level;
  clsp_pkg::store_cmd_t          cmd;

  // Fixed pair order as constant lookup tables.
  logic                          pair_ok  [LED_COUNT];
  logic [clsp_pkg::PNUM_W-1:0]   anode_tab[LED_COUNT];
  logic [clsp_pkg::PNUM_W-1:0]   cath_tab [LED_COUNT];

  for (genvar g = 0; g < LED_COUNT; g++) begin : g_pair
    localparam clsp_pkg::pair_t P = clsp_pkg::pair_of(g, PIN_COUNT);
    assign pair_ok[g]   = P.valid;
    assign anode_tab[g] = P.anode;
    assign cath_tab[g]  = P.cathode;
  end

  // Levels above MAX_LEVEL saturate when stored.
  assign sat_level = (a_lvl_r > clsp_pkg::LEVEL_W'(MAX_LEVEL))
                   ? clsp_pkg::STORE_W'(MAX_LEVEL)
                   : a_lvl_r[clsp_pkg::STORE_W-1:0];

  // An item leaves the input register once its result, if any, has room.
  assign has_res  = a_valid_r && ((a_mode_r == clsp_pkg::MODE_TICK && scan_r) ||
                                  a_mode_r == clsp_pkg::MODE_OFF);
  assign out_free = !out_valid_r || out_tready;
  assign a_fire   = a_valid_r && (!has_res || out_free);
  assign in_tready = !a_valid_r || a_fire;

  always_comb begin
    slot_nxt      = slot_r;
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r && !out_tready;
    en_nxt        = en_r;
    hi_nxt        = hi_r;
    total_nxt     = total_r;
    cmd           = '0;

    if (a_fire) begin
      unique case (a_mode_r)
        clsp_pkg::MODE_WRITE: begin
          scan_nxt    = 1'b1;
          cmd.wr      = (a_idx_r < clsp_pkg::IDX_W'(LED_COUNT));
          cmd.wr_addr = a_idx_r;
          cmd.wr_data = sat_level;
        end
        clsp_pkg::MODE_TICK: begin
          if (scan_r) begin
            en_nxt = '0;
            hi_nxt = '0;
            if (pair_ok[slot_r] && cur_level > phase_r) begin
              en_nxt = (clsp_pkg::PIN_W'(1) << anode_tab[slot_r]) |
                       (clsp_pkg::PIN_W'(1) << cath_tab[slot_r]);
              hi_nxt = clsp_pkg::PIN_W'(1) << anode_tab[slot_r];
            end
            // End of a sweep: count it and step the grayscale phase.
            if (slot_r == AW'(LED_COUNT - 1)) begin
              slot_nxt  = '0;
              count_nxt = count_r + 1'b1;
              phase_nxt = (phase_r == clsp_pkg::STORE_W'(MAX_LEVEL - 1))
                        ? '0 : phase_r + 1'b1;
            end else begin
              slot_nxt = slot_r + 1'b1;
            end
            out_valid_nxt = 1'b1;
            total_nxt     = count_nxt;
          end
        end
        clsp_pkg::MODE_OFF: begin
          scan_nxt      = 1'b0;
          cmd.clr       = 1'b1;
          out_valid_nxt = 1'b1;
          en_nxt        = '0;
          hi_nxt        = '0;
          total_nxt     = count_r;
        end
        default: begin
          // Unused mode code: the item is dropped.
        end
      endcase
    end

    // The store reads ahead the slot that the next item will see.
    cmd.rd_addr = clsp_pkg::IDX_W'(slot_nxt);
  end

  clsp_level_store #(
    .LED_COUNT(LED_COUNT)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_level(cur_level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      slot_r      <= '0;
      phase_r     <= '0;
      count_r     <= '0;
      scan_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        a_valid_r <= in_tvalid;
      end
      slot_r      <= slot_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_mode_r <= clsp_pkg::mode_t'(in_tuser);
      a_idx_r  <= in_tdata[6:0];
      a_lvl_r  <= in_tdata[14:7];
    end
    en_r    <= en_nxt;
    hi_r    <= hi_nxt;
    total_r <= total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, total_r, hi_r, en_r};

endmodule

`default_nettype wire
